// ===== src/rbx_pkg.sv =====
`timescale 1ns / 1ps

package rbx_pkg;

    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 12;
    localparam int DIST_W     = 24;
    localparam int MARGIN_W   = 8;
    localparam int WALL_W     = 3;
    localparam int REG_IDX_W  = 3;
    localparam int NUM_W      = COORD_W + FRAC_W;
    localparam int Q_W        = NUM_W;
    localparam int T_W        = Q_W + 2;
    localparam int DIV_STAGES = Q_W;
    localparam int LANES      = 6;
    localparam int AXES       = 3;

    localparam logic [REG_IDX_W-1:0] REG_LOW_X  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_X = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_Y  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOW_Z  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_Z = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN = 3'd6;

    localparam logic [WALL_W-1:0] WALL_LOW_X  = 3'd0;
    localparam logic [WALL_W-1:0] WALL_HIGH_X = 3'd1;
    localparam logic [WALL_W-1:0] WALL_LOW_Y  = 3'd2;
    localparam logic [WALL_W-1:0] WALL_HIGH_Y = 3'd3;
    localparam logic [WALL_W-1:0] WALL_LOW_Z  = 3'd4;
    localparam logic [WALL_W-1:0] WALL_HIGH_Z = 3'd5;
    localparam logic [WALL_W-1:0] WALL_NONE   = 3'd6;

    typedef struct packed {
        logic                              mode;
        logic [WALL_W-1:0]                 nwall;
        logic [WALL_W-1:0]                 cwall;
        logic [LANES-1:0][COORD_W-1:0]     nmag;
        logic [LANES-1:0]                  nneg;
        logic [AXES-1:0][COORD_W-1:0]      dmag;
        logic [AXES-1:0]                   dneg;
        logic [AXES-1:0]                   par;
        logic [AXES-1:0]                   in_box;
    } item_t;

    typedef struct packed {
        logic                              mode;
        logic [WALL_W-1:0]                 nwall;
        logic [WALL_W-1:0]                 cwall;
        logic [LANES-1:0]                  nneg;
        logic [AXES-1:0][COORD_W-1:0]      dmag;
        logic [AXES-1:0]                   dneg;
        logic [AXES-1:0]                   par;
        logic [AXES-1:0]                   in_box;
    } side_t;

    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [NUM_W-1:0]   num;
        logic [Q_W-1:0]     q;
    } div_lane_t;

    typedef struct packed {
        logic                         mode;
        logic                         ok;
        logic [WALL_W-1:0]            nwall;
        logic [WALL_W-1:0]            cwall;
        logic [AXES-1:0][T_W-1:0]     ent;
        logic [AXES-1:0][T_W-1:0]     ext;
    } slab_t;

    typedef struct packed {
        logic               mode;
        logic               ok;
        logic [WALL_W-1:0]  nwall;
        logic [WALL_W-1:0]  cwall;
        logic [T_W-1:0]     ent;
        logic [T_W-1:0]     ext;
    } span_t;

endpackage

// ===== src/rbx_front.sv =====
`timescale 1ns / 1ps

module rbx_front
    import rbx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [REG_IDX_W-1:0]        wr_index,
    input  logic [COORD_W-1:0]          wr_data,
    input  logic                        push,
    output logic                        full,
    input  logic                        mode,
    input  logic signed [COORD_W-1:0]   pos_x,
    input  logic signed [COORD_W-1:0]   pos_y,
    input  logic signed [COORD_W-1:0]   pos_z,
    input  logic signed [COORD_W-1:0]   dir_x,
    input  logic signed [COORD_W-1:0]   dir_y,
    input  logic signed [COORD_W-1:0]   dir_z,
    output logic                        q_push,
    input  logic                        q_full,
    output item_t                       q_item
);

    logic [COORD_W-1:0]  low_reg  [AXES];
    logic [COORD_W-1:0]  high_reg [AXES];
    logic [MARGIN_W-1:0] margin_reg;
    logic                valid_reg;
    item_t               item_reg;
    item_t               item_next;
    logic                accept;

    logic signed [COORD_W-1:0] pos [AXES];
    logic signed [COORD_W-1:0] dir [AXES];
    logic signed [COORD_W:0]   diff;
    logic signed [COORD_W:0]   dext;
    logic signed [COORD_W+1:0] p18;
    logic signed [COORD_W+1:0] m18;
    logic [LANES-1:0]          wall_hit;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                low_reg[a]  <= COORD_W'(-(1 << FRAC_W));
                high_reg[a] <= COORD_W'(1 << FRAC_W);
            end
            margin_reg <= MARGIN_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_LOW_X:  low_reg[0]  <= wr_data;
                REG_HIGH_X: high_reg[0] <= wr_data;
                REG_LOW_Y:  low_reg[1]  <= wr_data;
                REG_HIGH_Y: high_reg[1] <= wr_data;
                REG_LOW_Z:  low_reg[2]  <= wr_data;
                REG_HIGH_Z: high_reg[2] <= wr_data;
                REG_MARGIN: margin_reg  <= wr_data[MARGIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        item_next      = '0;
        item_next.mode = mode;
        wall_hit       = '0;
        diff           = '0;
        dext           = '0;
        p18            = '0;
        m18            = $signed({{(COORD_W+2-MARGIN_W){1'b0}}, margin_reg});
        for (int a = 0; a < AXES; a++)
        begin
            diff = $signed({low_reg[a][COORD_W-1], low_reg[a]})
                 - $signed({pos[a][COORD_W-1], pos[a]});
            item_next.nneg[2*a] = diff[COORD_W];
            item_next.nmag[2*a] = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
            diff = $signed({high_reg[a][COORD_W-1], high_reg[a]})
                 - $signed({pos[a][COORD_W-1], pos[a]});
            item_next.nneg[2*a+1] = diff[COORD_W];
            item_next.nmag[2*a+1] = diff[COORD_W] ? COORD_W'(-diff)
                                                  : diff[COORD_W-1:0];
            dext = $signed({dir[a][COORD_W-1], dir[a]});
            item_next.dneg[a] = dir[a][COORD_W-1];
            item_next.dmag[a] = dir[a][COORD_W-1] ? COORD_W'(-dext) : dext[COORD_W-1:0];
            item_next.par[a]  = (dir[a] == '0);
            item_next.in_box[a] = ($signed(pos[a]) >= $signed(low_reg[a]))
                               && ($signed(pos[a]) <= $signed(high_reg[a]));
            p18 = $signed({{2{pos[a][COORD_W-1]}}, pos[a]});
            wall_hit[2*a]   = p18 < $signed({{2{low_reg[a][COORD_W-1]}}, low_reg[a]}) + m18;
            wall_hit[2*a+1] = p18 > $signed({{2{high_reg[a][COORD_W-1]}}, high_reg[a]}) - m18;
        end

        item_next.nwall = WALL_NONE;
        item_next.cwall = WALL_NONE;
        if (mode)
        begin
            if (wall_hit[0])      item_next.nwall = WALL_LOW_X;
            else if (wall_hit[1]) item_next.nwall = WALL_HIGH_X;
            else if (wall_hit[2]) item_next.nwall = WALL_LOW_Y;
            else if (wall_hit[3]) item_next.nwall = WALL_HIGH_Y;
            else if (wall_hit[4]) item_next.nwall = WALL_LOW_Z;
            else if (wall_hit[5]) item_next.nwall = WALL_HIGH_Z;

            if (wall_hit[0])      item_next.cwall = WALL_LOW_X;
            else if (wall_hit[1]) item_next.cwall = WALL_HIGH_X;
            else if (wall_hit[3]) item_next.cwall = WALL_HIGH_Y;
            else if (wall_hit[2]) item_next.cwall = WALL_LOW_Y;
            else if (wall_hit[4]) item_next.cwall = WALL_LOW_Z;
            else if (wall_hit[5]) item_next.cwall = WALL_HIGH_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/rbx_queue.sv =====
`timescale 1ns / 1ps

module rbx_queue
    import rbx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t rd_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== src/rbx_back.sv =====
`timescale 1ns / 1ps

module rbx_back
    import rbx_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  item_t                      q_item,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic                       hit,
    output logic signed [DIST_W-1:0]   exit_distance,
    output logic [WALL_W-1:0]          normal_wall,
    output logic [WALL_W-1:0]          color_wall
);

    localparam logic signed [T_W-1:0] T_UNB    = {2'b01, {Q_W{1'b0}}};
    localparam logic signed [T_W-1:0] DIST_MAX = T_W'((1 << (DIST_W-1)) - 1);
    localparam logic signed [T_W-1:0] DIST_MIN = -DIST_MAX - T_W'(1);

    logic                     adv;
    logic [DIV_STAGES-1:0]    dv_valid_reg;
    div_lane_t [LANES-1:0]    dv_lane_reg [DIV_STAGES];
    side_t                    dv_side_reg [DIV_STAGES];
    div_lane_t [LANES-1:0]    step_in  [DIV_STAGES];
    div_lane_t [LANES-1:0]    step_out [DIV_STAGES];
    side_t                    side_in  [DIV_STAGES];

    logic                     a_valid_reg;
    slab_t                    a_reg;
    slab_t                    a_next;
    logic                     b_valid_reg;
    span_t                    b_reg;
    span_t                    b_next;
    logic                     out_valid_reg;
    logic                     hit_reg;
    logic                     hit_next;
    logic [DIST_W-1:0]        dist_reg;
    logic [DIST_W-1:0]        dist_next;
    logic [WALL_W-1:0]        nwall_reg;
    logic [WALL_W-1:0]        cwall_reg;

    logic [COORD_W:0]         trial;
    logic [COORD_W:0]         rdiff;
    logic [COORD_W-1:0]       dm;
    logic signed [T_W-1:0]    tl;
    logic signed [T_W-1:0]    th;
    side_t                    sd;
    logic signed [T_W-1:0]    ent_max;
    logic signed [T_W-1:0]    ext_min;

    assign adv   = !out_valid_reg || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !out_valid_reg;
    assign hit           = hit_reg;
    assign exit_distance = dist_reg;
    assign normal_wall   = nwall_reg;
    assign color_wall    = cwall_reg;

    always_comb
    begin
        side_in[0].mode   = q_item.mode;
        side_in[0].nwall  = q_item.nwall;
        side_in[0].cwall  = q_item.cwall;
        side_in[0].nneg   = q_item.nneg;
        side_in[0].dmag   = q_item.dmag;
        side_in[0].dneg   = q_item.dneg;
        side_in[0].par    = q_item.par;
        side_in[0].in_box = q_item.in_box;
        for (int l = 0; l < LANES; l++)
        begin
            step_in[0][l].rem = '0;
            step_in[0][l].num = {q_item.nmag[l], {FRAC_W{1'b0}}};
            step_in[0][l].q   = '0;
        end
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            step_in[s] = dv_lane_reg[s-1];
            side_in[s] = dv_side_reg[s-1];
        end
    end

    always_comb
    begin
        trial = '0;
        rdiff = '0;
        dm    = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                dm    = side_in[s].dmag[l/2];
                trial = {step_in[s][l].rem, step_in[s][l].num[NUM_W-1]};
                rdiff = trial - {1'b0, dm};
                step_out[s][l].num = {step_in[s][l].num[NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, dm})
                begin
                    step_out[s][l].rem = rdiff[COORD_W-1:0];
                    step_out[s][l].q   = {step_in[s][l].q[Q_W-2:0], 1'b1};
                end
                else
                begin
                    step_out[s][l].rem = trial[COORD_W-1:0];
                    step_out[s][l].q   = {step_in[s][l].q[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        sd           = dv_side_reg[DIV_STAGES-1];
        a_next       = '0;
        a_next.mode  = sd.mode;
        a_next.nwall = sd.nwall;
        a_next.cwall = sd.cwall;
        a_next.ok    = &(~sd.par | sd.in_box);
        tl           = '0;
        th           = '0;
        for (int a = 0; a < AXES; a++)
        begin
            tl = $signed({2'b00, dv_lane_reg[DIV_STAGES-1][2*a].q});
            th = $signed({2'b00, dv_lane_reg[DIV_STAGES-1][2*a+1].q});
            if (sd.nneg[2*a] ^ sd.dneg[a])
            begin
                tl = -tl;
            end
            if (sd.nneg[2*a+1] ^ sd.dneg[a])
            begin
                th = -th;
            end
            if (sd.par[a])
            begin
                a_next.ent[a] = -T_UNB;
                a_next.ext[a] = T_UNB;
            end
            else if (sd.dneg[a])
            begin
                a_next.ent[a] = th;
                a_next.ext[a] = tl;
            end
            else
            begin
                a_next.ent[a] = tl;
                a_next.ext[a] = th;
            end
        end
    end

    always_comb
    begin
        ent_max = $signed(a_reg.ent[0]);
        ext_min = $signed(a_reg.ext[0]);
        for (int a = 1; a < AXES; a++)
        begin
            if ($signed(a_reg.ent[a]) > ent_max)
            begin
                ent_max = $signed(a_reg.ent[a]);
            end
            if ($signed(a_reg.ext[a]) < ext_min)
            begin
                ext_min = $signed(a_reg.ext[a]);
            end
        end
        b_next.mode  = a_reg.mode;
        b_next.ok    = a_reg.ok;
        b_next.nwall = a_reg.nwall;
        b_next.cwall = a_reg.cwall;
        b_next.ent   = ent_max;
        b_next.ext   = ext_min;
    end

    always_comb
    begin
        hit_next  = !b_reg.mode && b_reg.ok && ($signed(b_reg.ent) <= $signed(b_reg.ext));
        dist_next = '0;
        if (hit_next)
        begin
            if ($signed(b_reg.ext) > DIST_MAX)
            begin
                dist_next = DIST_MAX[DIST_W-1:0];
            end
            else if ($signed(b_reg.ext) < DIST_MIN)
            begin
                dist_next = DIST_MIN[DIST_W-1:0];
            end
            else
            begin
                dist_next = b_reg.ext[DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg  <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg  <= {dv_valid_reg[DIV_STAGES-2:0], !q_empty};
            a_valid_reg   <= dv_valid_reg[DIV_STAGES-1];
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                dv_lane_reg[s] <= step_out[s];
                dv_side_reg[s] <= side_in[s];
            end
            a_reg     <= a_next;
            b_reg     <= b_next;
            hit_reg   <= hit_next;
            dist_reg  <= dist_next;
            nwall_reg <= b_reg.nwall;
            cwall_reg <= b_reg.cwall;
        end
    end

endmodule

// ===== src/ray_box_exit_and_wall_classify_top.sv =====
// A ray passes the front register, queue, divider stages, slab, span and result registers.
// Throughput: one transaction per cycle while the divider advances, set by the 28-stage pipelined slab divider.
// The divider advances as a whole only when the result register is free or being popped.
// Reset (rst_n, asynchronous, active low) empties the pipeline and the queue.
// Reset loads the box bounds to plus and minus one and the wall margin to one.
`timescale 1ns / 1ps

module ray_box_exit_and_wall_classify_top
    import rbx_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [REG_IDX_W-1:0]       wr_index,
    input  logic [COORD_W-1:0]         wr_data,
    input  logic                       push,
    output logic                       full,
    input  logic                       mode,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    input  logic signed [COORD_W-1:0]  pos_z,
    input  logic signed [COORD_W-1:0]  dir_x,
    input  logic signed [COORD_W-1:0]  dir_y,
    input  logic signed [COORD_W-1:0]  dir_z,
    output logic                       empty,
    input  logic                       pop,
    output logic                       hit,
    output logic signed [DIST_W-1:0]   exit_distance,
    output logic [WALL_W-1:0]          normal_wall,
    output logic [WALL_W-1:0]          color_wall
);

    logic  q_push;
    logic  q_full;
    item_t q_wr_item;
    logic  q_pop;
    logic  q_empty;
    item_t q_rd_item;

    rbx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .full     (full),
        .mode     (mode),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_item   (q_wr_item)
    );

    rbx_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (q_rd_item)
    );

    rbx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_rd_item),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .hit           (hit),
        .exit_distance (exit_distance),
        .normal_wall   (normal_wall),
        .color_wall    (color_wall)
    );

endmodule

// ===== src/rbx_checker.sv =====
`timescale 1ns / 1ps

module rbx_checker
    import rbx_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      empty,
    input logic                      pop,
    input logic                      hit,
    input logic signed [DIST_W-1:0]  exit_distance,
    input logic [WALL_W-1:0]         normal_wall,
    input logic [WALL_W-1:0]         color_wall
);

    a_hit_no_wall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit) |-> (normal_wall == WALL_NONE && color_wall == WALL_NONE))
        else $error("A hit result carries a wall code.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit) |-> (exit_distance == '0))
        else $error("A miss or classification result carries a distance.");

    a_walls_agree: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((normal_wall == WALL_NONE) == (color_wall == WALL_NONE)))
        else $error("Only one of the two wall orders found a wall.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(exit_distance) && $stable(hit)))
        else $error("A waiting result changed before it was popped.");

endmodule

bind ray_box_exit_and_wall_classify_top rbx_checker u_rbx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .hit           (hit),
    .exit_distance (exit_distance),
    .normal_wall   (normal_wall),
    .color_wall    (color_wall)
);

// ===== tb/tb_ray_box_exit_and_wall_classify_top.sv =====
`timescale 1ns / 1ps

module tb_ray_box_exit_and_wall_classify_top;
    import rbx_pkg::*;

    localparam longint DIST_HI    = 64'sd8388607;
    localparam longint DIST_LO    = -64'sd8388608;
    localparam longint FAR_AWAY   = 64'sd1 << 62;
    localparam int     DRAIN_WAIT = 40;
    localparam int     STALL_MAX  = 5000;
    localparam int     NUM_PHASES = 8;
    localparam int     PER_PHASE  = 230;

    typedef struct packed {
        logic                     hit;
        logic [DIST_W-1:0]        distance;
        logic [WALL_W-1:0]        nwall;
        logic [WALL_W-1:0]        cwall;
    } ray_result_t;

    typedef struct {
        logic                     mode;
        logic signed [COORD_W-1:0] px, py, pz, dx, dy, dz;
        bit                       fixed;
        ray_result_t              res;
    } ray_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       wr_en;
    logic [REG_IDX_W-1:0]       wr_index;
    logic [COORD_W-1:0]         wr_data;
    logic                       push;
    logic                       full;
    logic                       mode;
    logic signed [COORD_W-1:0]  pos_x, pos_y, pos_z;
    logic signed [COORD_W-1:0]  dir_x, dir_y, dir_z;
    logic                       empty;
    logic                       pop;
    logic                       hit;
    logic signed [DIST_W-1:0]   exit_distance;
    logic [WALL_W-1:0]          normal_wall;
    logic [WALL_W-1:0]          color_wall;

    longint      box_lo [3];
    longint      box_hi [3];
    longint      margin;
    ray_result_t pending_results [$];
    int          errors;
    int          stall_cycles;
    int          pop_gap;
    bit          idle_on;

    ray_box_exit_and_wall_classify_top dut (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .push(push), .full(full), .mode(mode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .empty(empty), .pop(pop), .hit(hit), .exit_distance(exit_distance),
        .normal_wall(normal_wall), .color_wall(color_wall)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic ray_result_t predict_ray_result(
        input logic m,
        input logic signed [COORD_W-1:0] px, py, pz, dx, dy, dz);
        ray_result_t r;
        longint p [3];
        longint d [3];
        longint enter, leave, t0, t1, t;
        bit ok;
        bit lx, hx, ly, hy, lz, hz;
        p[0] = px; p[1] = py; p[2] = pz;
        d[0] = dx; d[1] = dy; d[2] = dz;
        r.hit = 1'b0;
        r.distance = '0;
        r.nwall = WALL_NONE;
        r.cwall = WALL_NONE;
        if (!m)
        begin
            enter = -FAR_AWAY;
            leave = FAR_AWAY;
            ok = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                if (!ok)
                    continue;
                if (d[a] == 0)
                begin
                    if (p[a] < box_lo[a] || p[a] > box_hi[a])
                        ok = 1'b0;
                end
                else
                begin
                    t0 = ((box_lo[a] - p[a]) * 4096) / d[a];
                    t1 = ((box_hi[a] - p[a]) * 4096) / d[a];
                    if (d[a] < 0)
                    begin
                        t = t0;
                        t0 = t1;
                        t1 = t;
                    end
                    if (t0 > enter)
                        enter = t0;
                    if (t1 < leave)
                        leave = t1;
                end
            end
            if (ok && enter <= leave)
            begin
                r.hit = 1'b1;
                if (leave > DIST_HI)
                    leave = DIST_HI;
                if (leave < DIST_LO)
                    leave = DIST_LO;
                r.distance = leave[DIST_W-1:0];
            end
        end
        else
        begin
            lx = p[0] < box_lo[0] + margin;
            hx = p[0] > box_hi[0] - margin;
            ly = p[1] < box_lo[1] + margin;
            hy = p[1] > box_hi[1] - margin;
            lz = p[2] < box_lo[2] + margin;
            hz = p[2] > box_hi[2] - margin;
            if (lx) r.nwall = WALL_LOW_X;
            else if (hx) r.nwall = WALL_HIGH_X;
            else if (ly) r.nwall = WALL_LOW_Y;
            else if (hy) r.nwall = WALL_HIGH_Y;
            else if (lz) r.nwall = WALL_LOW_Z;
            else if (hz) r.nwall = WALL_HIGH_Z;
            if (lx) r.cwall = WALL_LOW_X;
            else if (hx) r.cwall = WALL_HIGH_X;
            else if (hy) r.cwall = WALL_HIGH_Y;
            else if (ly) r.cwall = WALL_LOW_Y;
            else if (lz) r.cwall = WALL_LOW_Z;
            else if (hz) r.cwall = WALL_HIGH_Z;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == REG_MARGIN)
            margin = val[MARGIN_W-1:0];
        else if (idx[0])
            box_hi[idx >> 1] = $signed(val);
        else
            box_lo[idx >> 1] = $signed(val);
    endtask

    task automatic drain_queue();
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic send_ray(input ray_row_t row);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        mode = row.mode;
        pos_x = row.px; pos_y = row.py; pos_z = row.pz;
        dir_x = row.dx; dir_y = row.dy; dir_z = row.dz;
        push = 1'b1;
        do
            @(posedge clk);
        while (full !== 1'b0);
        if (row.fixed)
            pending_results.push_back(row.res);
        else
            pending_results.push_back(predict_ray_result(row.mode, row.px, row.py,
                row.pz, row.dx, row.dy, row.dz));
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(input int axis, input bit near);
        longint lo, hi;
        if (!near)
            return COORD_W'($urandom);
        lo = (axis == 0) ? box_lo[0] : (axis == 1) ? box_lo[1] : box_lo[2];
        hi = (axis == 0) ? box_hi[0] : (axis == 1) ? box_hi[1] : box_hi[2];
        case ($urandom_range(0, 3))
            0: return COORD_W'(lo + $signed($urandom_range(0, 2 * margin + 2)) - margin - 1);
            1: return COORD_W'(hi + $signed($urandom_range(0, 2 * margin + 2)) - margin - 1);
            default: return COORD_W'($urandom_range(0, 1) ? lo + $urandom_range(0, 9000) :
                                                            hi - $urandom_range(0, 9000));
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COORD_W'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic ray_row_t random_row();
        ray_row_t row;
        bit near;
        near = $urandom_range(0, 3) != 0;
        row.mode = 1'($urandom_range(0, 1));
        row.px = rand_coord(0, near);
        row.py = rand_coord(1, near);
        row.pz = rand_coord(2, near);
        row.dx = rand_dir();
        row.dy = rand_dir();
        row.dz = rand_dir();
        row.fixed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    always @(posedge clk)
    begin
        ray_result_t want;
        if (rst_n && pop && empty === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("transactions with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (exit_distance !== want.distance)
                    report_mismatch("exit_distance", exit_distance, $signed(want.distance));
                if (normal_wall !== want.nwall)
                    report_mismatch("normal_wall", normal_wall, want.nwall);
                if (color_wall !== want.cwall)
                    report_mismatch("color_wall", color_wall, want.cwall);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && full === 1'b0) || (pop && empty === 1'b0) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (pop_gap > 0)
        begin
            pop = 1'b0;
            pop_gap--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pop = 1'b0;
            pop_gap = $urandom_range(0, 6);
        end
        else
            pop = 1'b1;
    end

    initial
    begin
        ray_row_t dir_rows [$];
        ray_row_t row;
        logic [COORD_W-1:0] a, b;
        errors = 0;
        stall_cycles = 0;
        pop_gap = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        push = 1'b0;
        pop = 1'b0;
        mode = 1'b0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = -4096;
            box_hi[i] = 4096;
        end
        margin = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows = '{
            '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_NONE, WALL_NONE}},
            '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b1, 24'h7fffff, WALL_NONE, WALL_NONE}},
            '{1'b0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_NONE, WALL_NONE}},
            '{1'b0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_NONE, WALL_NONE}},
            '{1'b1, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_LOW_X, WALL_LOW_X}},
            '{1'b1, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_HIGH_X, WALL_HIGH_X}},
            '{1'b1, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_HIGH_Y, WALL_HIGH_Y}},
            '{1'b1, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_LOW_Y, WALL_LOW_Y}},
            '{1'b1, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_LOW_Z, WALL_LOW_Z}},
            '{1'b1, 16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{1'b0, 24'd0, WALL_HIGH_Z, WALL_HIGH_Z}},
            '{1'b1, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
            '{1'b1, -16'sd4095, 16'sd4095, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
            '{1'b1, 16'sd4096, 16'sd4096, 16'sd4096, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              1'b0, '0},
            '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 1'b0, '0},
            '{1'b0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 16'sd0, 1'b0, '0},
            '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0},
            '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
            '{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd4096, 16'sd4096, 16'sd4096,
              1'b0, '0},
            '{1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sd4096, -16'sd1, -16'sd4096,
              1'b0, '0},
            '{1'b0, 16'sd8192, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 1'b0, '0},
            '{1'b0, 16'sd8192, 16'sd8192, 16'sd0, 16'sd4096, -16'sd4096, 16'sd0, 1'b0, '0},
            '{1'b0, 16'sd4096, -16'sd4096, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0}
        };
        foreach (dir_rows[i])
            send_ray(dir_rows[i]);
        @(negedge clk);
        push = 1'b0;
        drain_queue();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        write_reg(REG_IDX_W'(REG_LOW_X + 2 * i), 16'h8000);
                        write_reg(REG_IDX_W'(REG_HIGH_X + 2 * i), 16'h7fff);
                    end
                    write_reg(REG_MARGIN, 16'd255);
                end
                2:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        write_reg(REG_IDX_W'(REG_LOW_X + 2 * i), 16'h0400);
                        write_reg(REG_IDX_W'(REG_HIGH_X + 2 * i), 16'hfc00);
                    end
                    write_reg(REG_MARGIN, 16'd0);
                end
                3:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        write_reg(REG_IDX_W'(REG_LOW_X + 2 * i), 16'h7fff);
                        write_reg(REG_IDX_W'(REG_HIGH_X + 2 * i), 16'h8000);
                    end
                    write_reg(REG_MARGIN, 16'd128);
                end
                0:
                    ;
                default:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a = COORD_W'($urandom);
                        b = COORD_W'($urandom);
                        if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b))
                        begin
                            write_reg(REG_IDX_W'(REG_LOW_X + 2 * i), b);
                            write_reg(REG_IDX_W'(REG_HIGH_X + 2 * i), a);
                        end
                        else
                        begin
                            write_reg(REG_IDX_W'(REG_LOW_X + 2 * i), a);
                            write_reg(REG_IDX_W'(REG_HIGH_X + 2 * i), b);
                        end
                    end
                    write_reg(REG_MARGIN, COORD_W'($urandom_range(0, 255)));
                end
            endcase
            if (ph == NUM_PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < PER_PHASE; n++)
            begin
                row = random_row();
                send_ray(row);
            end
            @(negedge clk);
            push = 1'b0;
            drain_queue();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rbx_pkg.sv
src/rbx_front.sv
src/rbx_queue.sv
src/rbx_back.sv
src/ray_box_exit_and_wall_classify_top.sv
src/rbx_checker.sv
tb/tb_ray_box_exit_and_wall_classify_top.sv
